@@ rtl/hec_pkg.sv @@
// Shared types, constants and character tables for the HTML entity codec.
package hec_pkg;

  localparam int WINDOW_BYTES = 10;
  localparam int FILL_W       = $clog2(WINDOW_BYTES + 1);
  localparam int GLYPHS       = 25;
  localparam int GIDX_W       = $clog2(GLYPHS);
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  localparam logic [1:0] FMT_NAMED = 2'd0;
  localparam logic [1:0] FMT_DEC   = 2'd1;
  localparam logic [1:0] FMT_HEX   = 2'd2;

  localparam logic [1:0] EM_BYTE = 2'd0;
  localparam logic [1:0] EM_ENT  = 2'd1;
  localparam logic [1:0] EM_UTF  = 2'd2;

  localparam logic [1:0] ADDR_DIRECTION = 2'd0;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       semi;
  } item_t;

  typedef struct packed {
    logic              busy;
    logic [FILL_W-1:0] fill;
  } back_status_t;

  // UTF-8 sequences, right-justified, first byte highest
  localparam logic [2:0] GLEN [GLYPHS] = '{
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3};

  localparam logic [23:0] UTF8 [GLYPHS] = '{
    24'h000026, 24'h00003C, 24'h00003E, 24'h000022, 24'h000027, 24'h00002F,
    24'h000060, 24'h00003D, 24'h00C2A9, 24'h00C2AE, 24'hE284A2, 24'hE282AC,
    24'h00C2A3, 24'h00C2A5, 24'h00C2A2, 24'h00C2A7, 24'h00C2B6, 24'hE280A2,
    24'hE280A6, 24'hE28093, 24'hE28094, 24'hE28098, 24'hE28099, 24'hE2809C,
    24'hE2809D};

  // entity texts, right-justified, first character highest
  localparam logic [63:0] ENT_NAMED [GLYPHS] = '{
    64'("&amp;"), 64'("&lt;"), 64'("&gt;"), 64'("&quot;"), 64'("&#39;"),
    64'("&#x2F;"), 64'("&#x60;"), 64'("&#x3D;"), 64'("&copy;"), 64'("&reg;"),
    64'("&trade;"), 64'("&euro;"), 64'("&pound;"), 64'("&yen;"), 64'("&cent;"),
    64'("&sect;"), 64'("&para;"), 64'("&bull;"), 64'("&hellip;"), 64'("&ndash;"),
    64'("&mdash;"), 64'("&lsquo;"), 64'("&rsquo;"), 64'("&ldquo;"), 64'("&rdquo;")};

  localparam logic [63:0] ENT_DEC [GLYPHS] = '{
    64'("&#38;"), 64'("&#60;"), 64'("&#62;"), 64'("&#34;"), 64'("&#39;"),
    64'("&#x2F;"), 64'("&#x60;"), 64'("&#x3D;"), 64'("&#169;"), 64'("&#174;"),
    64'("&#8482;"), 64'("&#8364;"), 64'("&#163;"), 64'("&#165;"), 64'("&#162;"),
    64'("&#167;"), 64'("&#182;"), 64'("&#8226;"), 64'("&#8230;"), 64'("&#8211;"),
    64'("&#8212;"), 64'("&#8220;"), 64'("&#8221;"), 64'("&#8222;"), 64'("&#8223;")};

  localparam logic [63:0] ENT_HEX [GLYPHS] = '{
    64'("&#x26;"), 64'("&#x3C;"), 64'("&#x3E;"), 64'("&#x22;"), 64'("&#x27;"),
    64'("&#x2F;"), 64'("&#x60;"), 64'("&#x3D;"), 64'("&#169;"), 64'("&#174;"),
    64'("&#8482;"), 64'("&#8364;"), 64'("&#163;"), 64'("&#165;"), 64'("&#162;"),
    64'("&#167;"), 64'("&#182;"), 64'("&#8226;"), 64'("&#8230;"), 64'("&#8211;"),
    64'("&#8212;"), 64'("&#8220;"), 64'("&#8221;"), 64'("&#8222;"), 64'("&#8223;")};

  function automatic logic [63:0] ent_txt(logic [GIDX_W-1:0] g, logic [1:0] f);
    logic [63:0] t;
    case (f)
      FMT_NAMED: t = ENT_NAMED[g];
      FMT_DEC:   t = ENT_DEC[g];
      default:   t = ENT_HEX[g];
    endcase
    return t;
  endfunction

  function automatic logic [3:0] ent_len(logic [63:0] t);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 0; k < 8; k++) begin
      if (t[k*8 +: 8] != 8'd0) n = 4'(k + 1);
    end
    return n;
  endfunction

  function automatic logic [2:0] lead_len(logic [7:0] b);
    logic [2:0] n;
    if ((b & 8'hE0) == 8'hC0) n = 3'd2;
    else if ((b & 8'hF0) == 8'hE0) n = 3'd3;
    else if ((b & 8'hF8) == 8'hF0) n = 3'd4;
    else n = 3'd1;
    return n;
  endfunction

endpackage

@@ rtl/hec_front.sv @@
// Input front end: accepts stream bytes, tags semicolons, queues them for the engine.
module hec_front (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  input  logic           in_valid,
  output logic           in_stall,
  output hec_pkg::item_t q_item,
  output logic           q_valid,
  input  logic           q_pop
);
  import hec_pkg::*;

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign in_stall = (count == (QPTR_W+1)'(QDEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = mem[rd_ptr];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{data: in_byte, last: in_last, semi: (in_byte == CH_SEMI)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/hec_back.sv @@
// Conversion engine: lookahead window, table match, byte emission and output register.
module hec_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  direction,
  input  logic [1:0]            entity_format,
  input  hec_pkg::item_t        q_item,
  input  logic                  q_valid,
  output logic                  q_pop,
  output logic [7:0]            out_byte,
  output logic                  out_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output hec_pkg::back_status_t status
);
  import hec_pkg::*;

  localparam logic [1:0] S_FETCH = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [1:0]        state;
  logic [7:0]        win [WINDOW_BYTES];
  logic              semi_bits [WINDOW_BYTES];
  logic [FILL_W-1:0] fill;
  logic              lastf;

  logic [1:0]        em_src;
  logic [GIDX_W-1:0] em_g;
  logic [1:0]        em_f;
  logic [3:0]        em_len;
  logic [3:0]        em_k;
  logic [7:0]        em_byte;
  logic              em_fin;

  logic [1:0]        fmt;
  logic [7:0]        w0;
  logic [2:0]        n;
  logic              enc_hit;
  logic [GIDX_W-1:0] enc_g;
  logic [3:0]        semi_at;
  logic              semi_found;
  logic [4:0]        dlen;
  logic              dec_hit;
  logic [GIDX_W-1:0] dec_g;
  logic              enc_ok;
  logic              dec_ok;
  logic [63:0]       t;
  logic [3:0]        el;

  logic              ev_hold;
  logic [1:0]        ev_src;
  logic [GIDX_W-1:0] ev_g;
  logic [3:0]        ev_len;
  logic [7:0]        ev_byte;
  logic [FILL_W-1:0] ev_drop;
  logic [FILL_W-1:0] fill_left;
  logic [7:0]        win_sh [WINDOW_BYTES];
  logic              semi_sh [WINDOW_BYTES];

  logic              out_load;
  logic              em_end;
  logic [7:0]        cur_byte;
  logic [2:0]        bidx;
  logic [63:0]       cur_txt;
  logic [23:0]       cur_utf;

  assign fmt = (entity_format == 2'd3) ? FMT_NAMED : entity_format;
  assign w0  = win[0];
  assign n   = lead_len(w0);

  // encode table match
  always_comb begin
    enc_hit = 1'b0;
    enc_g   = '0;
    enc_ok  = 1'b0;
    for (int g = 0; g < GLYPHS; g++) begin
      enc_ok = (GLEN[g] == n) && ({1'b0, fill} >= (FILL_W+1)'(n));
      for (int k = 0; k < 3; k++) begin
        if (k < GLEN[g] && win[k] != UTF8[g][(GLEN[g]-1-k)*8 +: 8]) enc_ok = 1'b0;
      end
      if (enc_ok && !enc_hit) begin
        enc_hit = 1'b1;
        enc_g   = GIDX_W'(g);
      end
    end
  end

  // first semicolon after the ampersand
  always_comb begin
    semi_at = '0;
    for (int j = WINDOW_BYTES - 1; j >= 1; j--) begin
      if (j < fill && semi_bits[j]) semi_at = 4'(j);
    end
  end
  assign semi_found = (semi_at != '0);
  assign dlen       = {1'b0, semi_at} + 5'd1;

  // decode table match over all three forms
  always_comb begin
    dec_hit = 1'b0;
    dec_g   = '0;
    t       = '0;
    el      = '0;
    dec_ok  = 1'b0;
    for (int g = 0; g < GLYPHS; g++) begin
      for (int f = 0; f < 3; f++) begin
        t  = ent_txt(GIDX_W'(g), 2'(f));
        el = ent_len(t);
        dec_ok = semi_found && ({1'b0, el} == dlen);
        for (int k = 0; k < 8; k++) begin
          if (k < el && win[k] != t[(el-1-k)*8 +: 8]) dec_ok = 1'b0;
        end
        if (dec_ok && !dec_hit) begin
          dec_hit = 1'b1;
          dec_g   = GIDX_W'(g);
        end
      end
    end
  end

  always_comb begin
    ev_hold = 1'b0;
    ev_src  = EM_BYTE;
    ev_g    = '0;
    ev_len  = 4'd1;
    ev_byte = w0;
    ev_drop = FILL_W'(1);
    if (fill == '0) begin
      ev_hold = 1'b1;
    end else if (!direction) begin
      if ({1'b0, fill} < (FILL_W+1)'(n) && !lastf) begin
        ev_hold = 1'b1;
      end else if (enc_hit) begin
        ev_src  = EM_ENT;
        ev_g    = enc_g;
        ev_len  = ent_len(ent_txt(enc_g, fmt));
        ev_drop = FILL_W'(n);
      end
    end else begin
      if (w0 != CH_AMP) begin
        ev_byte = w0;
      end else if (!semi_found && fill < FILL_W'(WINDOW_BYTES) && !lastf) begin
        ev_hold = 1'b1;
      end else if (dec_hit) begin
        ev_src  = EM_UTF;
        ev_g    = dec_g;
        ev_len  = {1'b0, GLEN[dec_g]};
        ev_drop = FILL_W'(dlen);
      end else begin
        ev_byte = CH_AMP;
      end
    end
  end

  assign fill_left = fill - ev_drop;

  always_comb begin
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      win_sh[i]  = win[i];
      semi_sh[i] = semi_bits[i];
      for (int d = 1; d <= WINDOW_BYTES; d++) begin
        if (ev_drop == FILL_W'(d) && i + d < WINDOW_BYTES) begin
          win_sh[i]  = win[i+d];
          semi_sh[i] = semi_bits[i+d];
        end
      end
    end
  end

  // current emitted byte
  assign bidx    = 3'(em_len - 4'd1 - em_k);
  assign cur_txt = ent_txt(em_g, em_f);
  assign cur_utf = UTF8[em_g];
  always_comb begin
    case (em_src)
      EM_ENT:  cur_byte = cur_txt[{bidx, 3'b000} +: 8];
      EM_UTF:  cur_byte = cur_utf[{bidx[1:0], 3'b000} +: 8];
      default: cur_byte = em_byte;
    endcase
  end

  assign out_load = !out_valid || !out_stall;
  assign em_end   = (em_k == em_len - 4'd1);
  assign q_pop    = (state == S_FETCH) && q_valid;

  assign status = '{busy: (state != S_FETCH) || out_valid, fill: fill};

  always_ff @(posedge clk) begin
    if (q_pop) begin
      win[fill[FILL_W-1:0]]       <= q_item.data;
      semi_bits[fill[FILL_W-1:0]] <= q_item.semi;
    end else if (state == S_EVAL && !ev_hold) begin
      for (int i = 0; i < WINDOW_BYTES; i++) begin
        win[i]       <= win_sh[i];
        semi_bits[i] <= semi_sh[i];
      end
    end
    if (state == S_EVAL && !ev_hold) begin
      em_src  <= ev_src;
      em_g    <= ev_g;
      em_f    <= fmt;
      em_len  <= ev_len;
      em_byte <= ev_byte;
      em_fin  <= lastf && (fill_left == '0);
    end
    if (out_load) begin
      out_byte <= cur_byte;
      out_last <= em_fin && em_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FETCH;
      fill      <= '0;
      lastf     <= 1'b0;
      em_k      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= (state == S_EMIT);
      case (state)
        S_FETCH: begin
          if (q_pop) begin
            fill  <= fill + 1'b1;
            lastf <= q_item.last;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (ev_hold) begin
            state <= S_FETCH;
          end else begin
            fill  <= fill_left;
            em_k  <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            em_k <= em_k + 1'b1;
            if (em_end) state <= S_EVAL;
          end
        end
        default: state <= S_FETCH;
      endcase
    end
  end

endmodule

@@ rtl/html_entity_codec.sv @@
// Top level of the HTML entity codec: register port, front queue and conversion engine.
// Flow: an accepted byte waits in the queue until the engine, in its fetch state, moves it into
// the lookahead window; the engine then evaluates the window and emits the result through the
// output register, one byte at a time as out_stall allows. A pass-through byte goes through fetch,
// evaluate, emit, evaluate the emptied window; an entity or UTF-8 expansion emits each byte in turn.
// Reset (rst, synchronous): empties the queue and the window, clears direction and format.
module html_entity_codec (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic        in_valid,
  output logic        in_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_valid,
  input  logic        out_stall
);
  import hec_pkg::*;

  logic         direction;
  logic [1:0]   entity_format;
  logic         wr_en;
  item_t        q_item;
  logic         q_valid;
  logic         q_pop;
  back_status_t status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == ADDR_DIRECTION[0]) ? {31'd0, direction}
                                                  : {30'd0, entity_format};

  always_ff @(posedge clk) begin
    if (rst) begin
      direction     <= 1'b0;
      entity_format <= FMT_NAMED;
    end else if (wr_en) begin
      if (paddr[2] == ADDR_DIRECTION[0]) direction <= pwdata[0];
      else entity_format <= pwdata[1:0];
    end
  end

  hec_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop)
  );

  hec_back u_back (
    .clk           (clk),
    .rst           (rst),
    .direction     (direction),
    .entity_format (entity_format),
    .q_item        (q_item),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status)
  );

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    status.fill <= FILL_W'(WINDOW_BYTES))
    else $error("lookahead window overfilled");

  a_pop_fills: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (status.fill != '0) && status.busy)
    else $error("queued byte did not enter the window");

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_last) |-> status.busy)
    else $error("engine went idle mid-transaction");

endmodule

@@ tb/tb_html_entity_codec.sv @@
// Self-checking regression for the HTML entity codec: directed table plus random streams.
`timescale 1ns / 100ps

module tb_html_entity_codec;
  import hec_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] REG_DIRECTION = 3'd0;
  localparam logic [2:0] REG_FORMAT    = 3'd4;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } codec_byte_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [7:0] want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_valid;
  logic        out_stall;

  html_entity_codec i_dut (.*);

  // predictor state
  logic        dir_q;
  logic [1:0]  fmt_q;
  logic [7:0]  win_q [WINDOW_BYTES];
  int          fill_q;
  codec_byte_t pending_q [$];
  codec_byte_t expected_bytes [$];

  int   errors;
  int   cycles;
  int   send_idle_pct, recv_idle_pct;
  logic hold_recv;
  int   hold_len;

  // glyph table, as bytes
  int         g_len [GLYPHS];
  logic [7:0] g_utf [GLYPHS][4];
  string      g_ent [GLYPHS][3];

  initial begin
    g_len = '{1,1,1,1,1,1,1,1,2,2,3,3,2,2,2,2,2,3,3,3,3,3,3,3,3};
    g_utf = '{'{8'h26,0,0,0}, '{8'h3C,0,0,0}, '{8'h3E,0,0,0}, '{8'h22,0,0,0},
              '{8'h27,0,0,0}, '{8'h2F,0,0,0}, '{8'h60,0,0,0}, '{8'h3D,0,0,0},
              '{8'hC2,8'hA9,0,0}, '{8'hC2,8'hAE,0,0}, '{8'hE2,8'h84,8'hA2,0},
              '{8'hE2,8'h82,8'hAC,0}, '{8'hC2,8'hA3,0,0}, '{8'hC2,8'hA5,0,0},
              '{8'hC2,8'hA2,0,0}, '{8'hC2,8'hA7,0,0}, '{8'hC2,8'hB6,0,0},
              '{8'hE2,8'h80,8'hA2,0}, '{8'hE2,8'h80,8'hA6,0}, '{8'hE2,8'h80,8'h93,0},
              '{8'hE2,8'h80,8'h94,0}, '{8'hE2,8'h80,8'h98,0}, '{8'hE2,8'h80,8'h99,0},
              '{8'hE2,8'h80,8'h9C,0}, '{8'hE2,8'h80,8'h9D,0}};
    g_ent = '{'{"&amp;","&#38;","&#x26;"}, '{"&lt;","&#60;","&#x3C;"},
              '{"&gt;","&#62;","&#x3E;"}, '{"&quot;","&#34;","&#x22;"},
              '{"&#39;","&#39;","&#x27;"}, '{"&#x2F;","&#x2F;","&#x2F;"},
              '{"&#x60;","&#x60;","&#x60;"}, '{"&#x3D;","&#x3D;","&#x3D;"},
              '{"&copy;","&#169;","&#169;"}, '{"&reg;","&#174;","&#174;"},
              '{"&trade;","&#8482;","&#8482;"}, '{"&euro;","&#8364;","&#8364;"},
              '{"&pound;","&#163;","&#163;"}, '{"&yen;","&#165;","&#165;"},
              '{"&cent;","&#162;","&#162;"}, '{"&sect;","&#167;","&#167;"},
              '{"&para;","&#182;","&#182;"}, '{"&bull;","&#8226;","&#8226;"},
              '{"&hellip;","&#8230;","&#8230;"}, '{"&ndash;","&#8211;","&#8211;"},
              '{"&mdash;","&#8212;","&#8212;"}, '{"&lsquo;","&#8220;","&#8220;"},
              '{"&rsquo;","&#8221;","&#8221;"}, '{"&ldquo;","&#8222;","&#8222;"},
              '{"&rdquo;","&#8223;","&#8223;"}};
  end

  function automatic void emit_byte(logic [7:0] b);
    pending_q.insert(pending_q.size(), '{data: b, last: 1'b0});
  endfunction

  function automatic void shift_window(int n);
    if (n > fill_q) n = fill_q;
    for (int k = 0; k + n < fill_q; k++) win_q[k] = win_q[k + n];
    fill_q -= n;
  endfunction

  function automatic int utf_len(logic [7:0] b);
    if ((b & 8'hE0) == 8'hC0) return 2;
    if ((b & 8'hF0) == 8'hE0) return 3;
    if ((b & 8'hF8) == 8'hF0) return 4;
    return 1;
  endfunction

  function automatic void encode_window(logic last);
    int f, n;
    logic hit, same;
    f = (fmt_q > 2'd2) ? 0 : int'(fmt_q);
    while (fill_q > 0) begin
      n = utf_len(win_q[0]);
      hit = 1'b0;
      if (fill_q < n) begin
        if (!last) break;
      end else begin
        for (int g = 0; g < GLYPHS && !hit; g++) begin
          if (g_len[g] == n) begin
            same = 1'b1;
            for (int k = 0; k < n; k++) if (win_q[k] != g_utf[g][k]) same = 1'b0;
            if (same) begin
              for (int k = 0; k < g_ent[g][f].len(); k++) emit_byte(g_ent[g][f][k]);
              shift_window(n);
              hit = 1'b1;
            end
          end
        end
      end
      if (!hit) begin
        emit_byte(win_q[0]);
        shift_window(1);
      end
    end
  endfunction

  function automatic void decode_window(logic last);
    int span, semi, len;
    logic hit, same;
    while (fill_q > 0) begin
      if (win_q[0] != CH_AMP) begin
        emit_byte(win_q[0]);
        shift_window(1);
        continue;
      end
      span = (fill_q < WINDOW_BYTES) ? fill_q : WINDOW_BYTES;
      semi = 0;
      for (int j = 1; j < span; j++) if (semi == 0 && win_q[j] == CH_SEMI) semi = j;
      if (semi == 0 && fill_q < WINDOW_BYTES && !last) break;
      hit = 1'b0;
      if (semi != 0) begin
        len = semi + 1;
        for (int g = 0; g < GLYPHS && !hit; g++) begin
          for (int f = 0; f < 3 && !hit; f++) begin
            if (g_ent[g][f].len() == len) begin
              same = 1'b1;
              for (int k = 0; k < len; k++) if (win_q[k] != g_ent[g][f][k]) same = 1'b0;
              if (same) begin
                for (int k = 0; k < g_len[g]; k++) emit_byte(g_utf[g][k]);
                shift_window(len);
                hit = 1'b1;
              end
            end
          end
        end
      end
      if (!hit) begin
        emit_byte(CH_AMP);
        shift_window(1);
      end
    end
  endfunction

  // stream-level prediction: output order matters, step grouping does not
  function automatic void predict_codec(logic [7:0] b, logic last);
    if (fill_q < WINDOW_BYTES) begin
      win_q[fill_q] = b;
      fill_q++;
    end
    if (dir_q) decode_window(last);
    else encode_window(last);
    if (last) begin
      shift_window(fill_q);
      if (pending_q.size() > 0) pending_q[pending_q.size() - 1].last = 1'b1;
    end
    while (pending_q.size() > 0)
      expected_bytes.insert(expected_bytes.size(), pending_q.pop_front());
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("html_entity_codec regression: fail");
      $finish;
    end
  end

  // output monitor
  always @(posedge clk) begin
    codec_byte_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected out_byte %h", out_byte);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte expected %h actual %h", want.data, out_byte);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("out_last expected %b actual %b", want.last, out_last);
          errors++;
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_recv) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    hold_recv = 1'b0;
    wait (hold_len > 0);
    hold_recv = 1'b1;
    repeat (hold_len) @(negedge clk);
    hold_recv = 1'b0;
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == REG_DIRECTION) dir_q = data[0];
    else fmt_q = data[1:0];
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic drain_codec();
    if (in_valid) in_valid <= 1'b0;
    while (expected_bytes.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(logic [7:0] b, logic last, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; in_byte <= b; in_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_codec(b, last);
    @(negedge clk);
  endtask

  task automatic send_row(stim_row_t r);
    if (r.typed) drain_codec();
    send_byte(r.data, r.last, send_idle_pct);
    if (r.typed) begin
      if (expected_bytes.size() != 1) begin
        $error("out_byte count expected 1 actual %0d", expected_bytes.size());
        errors++;
      end else if (expected_bytes[0].data != r.want) begin
        $error("out_byte expected %h actual %h", r.want, expected_bytes[0].data);
        errors++;
      end
    end
  endtask

  task automatic send_text(string s, logic close);
    for (int k = 0; k < s.len(); k++)
      send_byte(s[k], close && (k == s.len() - 1), send_idle_pct);
  endtask

  task automatic random_stream(int nbytes);
    int g, f, kind;
    string s;
    for (int k = 0; k < nbytes; ) begin
      kind = $urandom_range(9);
      g = $urandom_range(GLYPHS - 1);
      f = $urandom_range(2);
      s = "";
      if (kind < 4 && !dir_q) for (int j = 0; j < g_len[g]; j++) s = {s, string'(g_utf[g][j])};
      else if (kind < 4) s = g_ent[g][f];
      else if (kind < 6) begin
        s = dir_q ? g_ent[g][f] : "";
        if (!dir_q) s = {string'(g_utf[g][0])};
        if (s.len() > 2) s = s.substr(0, $urandom_range(s.len() - 2));
      end else s = {string'(8'($urandom_range(255)))};
      for (int j = 0; j < s.len(); j++, k++)
        send_byte(s[j], (k == nbytes - 1) || ($urandom_range(40) == 0), send_idle_pct);
    end
    if (fill_q > 0) send_byte(8'($urandom_range(255)), 1'b1, send_idle_pct);
  endtask

  stim_row_t directed_rows [] = '{
    '{8'h41, 1'b1, 1'b1, 8'h41},
    '{8'h00, 1'b1, 1'b1, 8'h00},
    '{8'hFF, 1'b1, 1'b1, 8'hFF},
    '{8'h3C, 1'b0, 1'b0, 8'h00},
    '{8'hC2, 1'b0, 1'b0, 8'h00},
    '{8'hA9, 1'b0, 1'b0, 8'h00},
    '{8'hE2, 1'b0, 1'b0, 8'h00},
    '{8'h80, 1'b0, 1'b0, 8'h00},
    '{8'hA6, 1'b0, 1'b0, 8'h00},
    '{8'hE2, 1'b0, 1'b0, 8'h00},
    '{8'h80, 1'b1, 1'b0, 8'h00},
    '{8'hF0, 1'b0, 1'b0, 8'h00},
    '{8'h9F, 1'b0, 1'b0, 8'h00},
    '{8'h98, 1'b0, 1'b0, 8'h00},
    '{8'h80, 1'b1, 1'b0, 8'h00},
    '{8'hC2, 1'b0, 1'b0, 8'h00},
    '{8'h41, 1'b1, 1'b0, 8'h00}
  };

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_byte = '0; in_last = 1'b0; in_valid = 1'b0;
    dir_q = 1'b0; fmt_q = FMT_NAMED; fill_q = 0;
    errors = 0; cycles = 0; hold_len = 0;
    send_idle_pct = 21; recv_idle_pct = 62;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) send_row(directed_rows[i]);
    drain_codec();
    for (int f = 1; f <= 3; f++) begin
      apb_write(REG_FORMAT, f);
      send_text("<\xc2\xae\xe2\x84\xa2&\"", 1'b1);
      drain_codec();
    end
    apb_write(REG_DIRECTION, 1);
    send_text("&lt;&#8482;&#x3E;&bogus;&amp&abcdefghijk;x&", 1'b1);
    drain_codec();

    // long receiver hold-off while the sender keeps offering
    hold_len = 300;
    send_text("&hellip;&hellip;&hellip;&copy;&reg;&#8230;", 1'b1);
    drain_codec();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 62 : 0;
      recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 21 : 0;
      for (int m = 0; m < 2; m++) begin
        apb_write(REG_DIRECTION, $urandom_range(1));
        apb_write(REG_FORMAT, $urandom_range(3));
        random_stream(40);
        drain_codec();
      end
    end

    drain_codec();
    if (errors == 0) $display("html_entity_codec regression: pass");
    else $display("html_entity_codec regression: fail");
    $finish;
  end

endmodule
